@@ hdl/class_label_timeout_filter_defines.svh @@
// ----------------------------------------------------------------------------
// class_label_timeout_filter_defines.svh
// Assertion macros for the checker file of the label timeout filter.
// ----------------------------------------------------------------------------
`ifndef CLASS_LABEL_TIMEOUT_FILTER_DEFINES_SVH
`define CLASS_LABEL_TIMEOUT_FILTER_DEFINES_SVH

// Same-cycle implication, checked on the rising edge, off during reset
`define CLTF_ASSERT_SAME(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("class_label_timeout_filter: check failed");

// Next-cycle implication, checked on the rising edge, off during reset
`define CLTF_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("class_label_timeout_filter: check failed");

`endif

@@ hdl/clatf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clatf_pkg
// Types, sizes and codes shared by the label timeout filter modules.
// ----------------------------------------------------------------------------
package clatf_pkg;

	// Timer table size and derived widths
	localparam int MAX_TIMERS = 16;
	localparam int IDX_W      = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
	localparam int CNT_W      = $clog2(MAX_TIMERS + 1);

	// Field widths
	localparam int LABEL_W    = 16;
	localparam int TICK_W     = 32;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 32;

	// Item operation codes
	localparam logic OP_LABEL = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	// Filter mode codes
	localparam logic MODE_SHARED = 1'b0;
	localparam logic MODE_INDEP  = 1'b1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = CFG_IDX_W'(1);

	// Input word
	typedef struct packed {
		logic               operation;
		logic [LABEL_W-1:0] class_label;
	} in_word_t;

	// Result word
	typedef struct packed {
		logic [LABEL_W-1:0] filtered_label;
		logic               table_full;
	} out_word_t;

	// Request from the sequencer to the timer table
	typedef struct packed {
		logic               rd_en;
		logic [IDX_W-1:0]   rd_idx;
		logic               wr_en;
		logic               vld_set;
		logic               vld_clr;
		logic               clr_all;
		logic [IDX_W-1:0]   idx;
		logic [LABEL_W-1:0] label;
		logic [TICK_W-1:0]  remaining;
	} tbl_req_t;

	// Registered read response of the timer table
	typedef struct packed {
		logic               vld;
		logic [LABEL_W-1:0] label;
		logic [TICK_W-1:0]  remaining;
	} tbl_rsp_t;

	// Shared entry unit results
	typedef struct packed {
		logic              label_eq;
		logic              rem_nz;
		logic [TICK_W-1:0] rem_dec;
	} unit_res_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_APPLY
	} state_t;

endpackage

@@ hdl/clatf_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clatf_unit
// Shared entry unit: label compare, expiry test and countdown of one timer.
// ----------------------------------------------------------------------------
module clatf_unit (
	input  logic [clatf_pkg::LABEL_W-1:0] entry_label,
	input  logic [clatf_pkg::TICK_W-1:0]  entry_rem,
	input  logic [clatf_pkg::LABEL_W-1:0] key_label,
	output clatf_pkg::unit_res_t          res
);
	import clatf_pkg::*;

	// Compare label, test for a running timer, count down by one
	assign res.label_eq = (entry_label == key_label);
	assign res.rem_nz   = |entry_rem;
	assign res.rem_dec  = entry_rem - TICK_W'(1);

endmodule

@@ hdl/clatf_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clatf_table
// Timer table: label and remaining count in a memory with one write and one
// registered read port, valid bits in flops cleared by reset or config write.
// ----------------------------------------------------------------------------
module clatf_table (
	input  logic                clk,
	input  logic                arst_n,
	input  clatf_pkg::tbl_req_t req,
	output clatf_pkg::tbl_rsp_t rsp,
	output logic                empty
);
	import clatf_pkg::*;

	localparam int WORD_W = LABEL_W + TICK_W;

	logic [MAX_TIMERS-1:0] vld_q;
	logic [WORD_W-1:0]     mem [MAX_TIMERS];
	logic [WORD_W-1:0]     rd_data_q;
	logic                  rd_vld_q;

	// Set, clear or flush the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (req.clr_all) begin
			vld_q <= '0;
		end else if (req.vld_set) begin
			vld_q[req.idx] <= 1'b1;
		end else if (req.vld_clr) begin
			vld_q[req.idx] <= 1'b0;
		end
	end

	// Write one entry
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.idx] <= {req.label, req.remaining};
		end
	end

	// Read one entry, registered
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data_q <= mem[req.rd_idx];
			rd_vld_q  <= vld_q[req.rd_idx];
		end
	end

	assign rsp.vld       = rd_vld_q;
	assign rsp.label     = rd_data_q[WORD_W-1:TICK_W];
	assign rsp.remaining = rd_data_q[TICK_W-1:0];
	assign empty         = ~|vld_q;

endmodule

@@ hdl/class_label_timeout_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// class_label_timeout_filter
// Suppresses repeated classifier labels for a timeout counted in tick words.
// ----------------------------------------------------------------------------
// One word is worked on at a time; item_stall is high until it is done. The
// sequencer walks the timer table one entry per cycle through the table's
// single registered read port and one shared compare/countdown unit. A tick
// word walks every entry, a label in independent mode walks every entry and
// then applies its result, a label in shared mode reads only entry 0, and
// a null label on an empty table skips the walk. A finished result waits in
// the output register and holds the next label word only if it is still not
// taken when that word finishes. Register writes are taken while no word is
// in work and go ahead of a word offered in the same cycle; a write to either
// register clears the whole table at once.
// ----------------------------------------------------------------------------
module class_label_timeout_filter (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_stall,
	input  clatf_pkg::in_word_t              item,
	output logic                             result_valid,
	input  logic                             result_stall,
	output clatf_pkg::out_word_t             result,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [clatf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [clatf_pkg::CFG_DATA_W-1:0] cfg_data
);
	import clatf_pkg::*;

	state_t              state_q, state_d;
	logic                mode_q;
	logic [TICK_W-1:0]   timeout_q;
	logic                op_q;
	logic [LABEL_W-1:0]  lbl_q;
	logic                trivial_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                proc_vld_s1;
	logic [IDX_W-1:0]    proc_idx_s1;
	logic                match_found_q, match_run_q;
	logic [IDX_W-1:0]    match_idx_q;
	logic                free_found_q;
	logic [IDX_W-1:0]    free_idx_q;
	logic                out_vld_q;
	out_word_t           out_q, out_d;
	logic                out_load;

	tbl_req_t            req;
	tbl_rsp_t            rsp;
	logic                tbl_empty;
	unit_res_t           ures;

	logic                accept_in, cfg_we, cfg_hit, out_free;
	logic                trivial_in;
	logic [CNT_W-1:0]    sweep_len;
	logic                is_match, is_stale, is_free;

	clatf_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.empty  (tbl_empty)
	);

	clatf_unit u_unit (
		.entry_label (rsp.label),
		.entry_rem   (rsp.remaining),
		.key_label   (lbl_q),
		.res         (ures)
	);

	// Handshakes; a pending register write goes ahead of an input word
	assign item_stall   = (state_q != ST_IDLE) || cfg_valid;
	assign cfg_ready    = (state_q == ST_IDLE);
	assign accept_in    = item_valid && !item_stall;
	assign cfg_we       = cfg_valid && cfg_ready;
	assign cfg_hit      = cfg_we && (cfg_index == REG_FILTER_MODE ||
		cfg_index == REG_TIMEOUT_TICKS);
	assign out_free     = !out_vld_q || !result_stall;
	assign result_valid = out_vld_q;
	assign result       = out_q;

	// Null label on an empty table needs no table walk
	assign trivial_in = (item.operation == OP_LABEL) &&
		(item.class_label == '0) && tbl_empty;

	// Shared mode labels only look at entry 0
	assign sweep_len = (op_q == OP_LABEL && mode_q == MODE_SHARED) ?
		CNT_W'(1) : CNT_W'(MAX_TIMERS);

	// Classify the entry coming back from the table
	assign is_match = rsp.vld && (mode_q == MODE_SHARED || ures.label_eq);
	assign is_stale = rsp.vld && !is_match && !ures.rem_nz;
	assign is_free  = !rsp.vld || is_stale;

	// Next state, table requests and result word
	always_comb begin
		state_d  = state_q;
		req      = '0;
		out_load = 1'b0;
		out_d.filtered_label = lbl_q;
		out_d.table_full     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req.clr_all = cfg_hit;
				if (accept_in) begin
					state_d = trivial_in ? ST_APPLY : ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				// issue the next read
				if (cnt_q < sweep_len) begin
					req.rd_en  = 1'b1;
					req.rd_idx = cnt_q[IDX_W-1:0];
				end
				// count down or free the entry read last cycle
				if (proc_vld_s1) begin
					req.idx = proc_idx_s1;
					if (op_q == OP_TICK) begin
						if (rsp.vld && ures.rem_nz) begin
							req.wr_en     = 1'b1;
							req.label     = rsp.label;
							req.remaining = ures.rem_dec;
						end
					end else if (is_stale) begin
						req.vld_clr = 1'b1;
					end
				end
				if (cnt_q == sweep_len) begin
					state_d = (op_q == OP_TICK) ? ST_IDLE : ST_APPLY;
				end
			end
			ST_APPLY: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
					if (trivial_q) begin
						out_d.filtered_label = '0;
					end else if (match_found_q) begin
						req.idx = match_idx_q;
						if (match_run_q) begin
							// timer still running: suppress
							out_d.filtered_label = '0;
						end else if (mode_q == MODE_SHARED && lbl_q == '0) begin
							// expired shared timer and a null label: free it
							req.vld_clr          = 1'b1;
							out_d.filtered_label = '0;
						end else begin
							// expired: restart and pass
							req.wr_en     = 1'b1;
							req.label     = lbl_q;
							req.remaining = timeout_q;
						end
					end else if (free_found_q) begin
						// new timer in the lowest free entry
						req.idx       = free_idx_q;
						req.wr_en     = 1'b1;
						req.vld_set   = 1'b1;
						req.label     = lbl_q;
						req.remaining = timeout_q;
					end else begin
						out_d.table_full = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State, registers and sweep bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			mode_q        <= MODE_SHARED;
			timeout_q     <= '0;
			cnt_q         <= '0;
			proc_vld_s1   <= 1'b0;
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
			trivial_q     <= 1'b0;
			out_vld_q     <= 1'b0;
		end else begin
			state_q     <= state_d;
			proc_vld_s1 <= req.rd_en;

			// register writes
			if (cfg_we && cfg_index == REG_FILTER_MODE) begin
				mode_q <= cfg_data[0];
			end
			if (cfg_we && cfg_index == REG_TIMEOUT_TICKS) begin
				timeout_q <= cfg_data;
			end

			// start a word
			if (accept_in) begin
				trivial_q     <= trivial_in;
				cnt_q         <= '0;
				match_found_q <= 1'b0;
				free_found_q  <= 1'b0;
			end

			// advance the read pointer
			if (req.rd_en) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end

			// remember first match and lowest free entry
			if (state_q == ST_SWEEP && proc_vld_s1 && op_q == OP_LABEL) begin
				if (is_match && !match_found_q) begin
					match_found_q <= 1'b1;
				end
				if (is_free && !free_found_q) begin
					free_found_q <= 1'b1;
				end
			end

			// hold the result until taken
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (out_vld_q && !result_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept_in) begin
			op_q  <= item.operation;
			lbl_q <= item.class_label;
		end
		if (req.rd_en) begin
			proc_idx_s1 <= req.rd_idx;
		end
		if (state_q == ST_SWEEP && proc_vld_s1 && op_q == OP_LABEL) begin
			if (is_match && !match_found_q) begin
				match_idx_q <= proc_idx_s1;
				match_run_q <= ures.rem_nz;
			end
			if (is_free && !free_found_q) begin
				free_idx_q <= proc_idx_s1;
			end
		end
		if (out_load) begin
			out_q <= out_d;
		end
	end

endmodule

@@ hdl/clatf_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clatf_checker
// Port-level checks of the label timeout filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "class_label_timeout_filter_defines.svh"

module clatf_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 item_valid,
	input logic                 item_stall,
	input logic                 result_valid,
	input logic                 result_stall,
	input clatf_pkg::out_word_t result
);
	import clatf_pkg::*;

	// A stalled result stays offered
	`CLTF_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid)

	// A stalled result word does not change
	`CLTF_ASSERT_NEXT(a_result_stable, result_valid && result_stall, $stable(result))

	// An accepted word leaves the block busy in the next cycle
	`CLTF_ASSERT_NEXT(a_busy_after_accept, item_valid && !item_stall, item_stall)

	// A new result only appears at the end of work on a word
	`CLTF_ASSERT_SAME(a_result_from_work, $rose(result_valid), $past(item_stall))

endmodule

bind class_label_timeout_filter clatf_checker u_clatf_checker (.*);

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the class label timeout filter.
// ----------------------------------------------------------------------------
// Label and tick words go in through the stall handshake. Each accepted word
// runs through a local model of the timer table. A label word queues the
// filtered label it should give, and a tick word only counts timers down.
// Results are checked in order, field by field. Directed words cover the
// reset state, the shared timeout and a full table, then a long output
// hold-off and a sender pause. Random phases then sweep both modes and a
// spread of timeouts, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;
	import clatf_pkg::*;

	localparam int IDLE_PCT      = 21;
	localparam int SETTLE_CYCLES = 2 * MAX_TIMERS + 8;
	localparam int STALL_LIMIT   = 3000;
	localparam int HOLD_CYCLES   = 300;
	localparam int MAX_REPORTS   = 10;

	logic                  clk;
	logic                  arst_n;
	logic                  item_valid;
	logic                  item_stall;
	in_word_t              item;
	logic                  result_valid;
	logic                  result_stall;
	out_word_t             result;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Local copy of the registers and the timer table
	logic               mdl_mode;
	logic [TICK_W-1:0]  mdl_timeout;
	logic               timer_live [MAX_TIMERS];
	logic [LABEL_W-1:0] timer_label [MAX_TIMERS];
	logic [TICK_W-1:0]  timer_left [MAX_TIMERS];

	out_word_t due_labels[$];
	int        fault_count;
	int        quiet_cycles;
	int        rx_hold;
	bit        steady;

	class_label_timeout_filter uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Free every timer
	function automatic void clear_timers();
		for (int i = 0; i < MAX_TIMERS; i++) begin
			timer_live[i]  = 1'b0;
			timer_label[i] = '0;
			timer_left[i]  = '0;
		end
	endfunction

	// Advance the timer table by one word; return 1 when the word gives a result
	function automatic bit filter_word(input in_word_t w, output out_word_t r);
		logic [LABEL_W-1:0] lbl;
		bit                 any_live;
		int                 hit;
		int                 slot;

		lbl = w.class_label;
		r   = '0;
		if (w.operation == OP_TICK) begin
			for (int i = 0; i < MAX_TIMERS; i++)
				if (timer_live[i] && timer_left[i] != 0)
					timer_left[i] = timer_left[i] - 1;
			return 1'b0;
		end
		any_live = 1'b0;
		for (int i = 0; i < MAX_TIMERS; i++)
			any_live |= timer_live[i];
		if (lbl == 0 && !any_live)
			return 1'b1;

		if (mdl_mode == MODE_SHARED) begin
			if (timer_live[0] && timer_left[0] != 0) begin
				r.filtered_label = '0;
			end else begin
				if (timer_live[0])
					clear_timers();
				if (lbl != 0) begin
					timer_live[0]    = 1'b1;
					timer_label[0]   = lbl;
					timer_left[0]    = mdl_timeout;
					r.filtered_label = lbl;
				end
			end
			return 1'b1;
		end

		// Independent mode: free expired timers of other labels, find a match
		hit = -1;
		for (int i = 0; i < MAX_TIMERS; i++) begin
			if (timer_live[i] && timer_label[i] == lbl) begin
				if (hit < 0)
					hit = i;
			end else if (timer_live[i] && timer_left[i] == 0) begin
				timer_live[i]  = 1'b0;
				timer_label[i] = '0;
			end
		end
		if (hit >= 0) begin
			if (timer_left[hit] != 0) begin
				r.filtered_label = '0;
			end else begin
				timer_left[hit]  = mdl_timeout;
				r.filtered_label = lbl;
			end
			return 1'b1;
		end
		slot = -1;
		for (int i = 0; i < MAX_TIMERS; i++)
			if (!timer_live[i] && slot < 0)
				slot = i;
		if (slot >= 0) begin
			timer_live[slot]  = 1'b1;
			timer_label[slot] = lbl;
			timer_left[slot]  = mdl_timeout;
		end else begin
			r.table_full = 1'b1;
		end
		r.filtered_label = lbl;
		return 1'b1;
	endfunction

	// Count a failure; show only the first few
	task automatic report_fault(input string msg);
		fault_count++;
		if (fault_count <= MAX_REPORTS)
			$display("%0t ns: %s", $time, msg);
	endtask

	// Offer one word, optionally after an idle gap, and wait until it is taken
	task automatic send_word(input in_word_t w);
		out_word_t r;

		@(negedge clk);
		if (!steady && $urandom_range(99) < IDLE_PCT) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		item_valid <= 1'b1;
		item       <= w;
		do @(posedge clk); while (item_stall);
		if (filter_word(w, r))
			due_labels = {due_labels, r};
	endtask

	task automatic send_label(input logic [LABEL_W-1:0] lbl);
		send_word('{operation: OP_LABEL, class_label: lbl});
	endtask

	task automatic send_tick();
		send_word('{operation: OP_TICK, class_label: LABEL_W'($urandom)});
	endtask

	// Drop valid and wait until every queued result has come back
	task automatic wait_drained();
		@(negedge clk);
		item_valid <= 1'b0;
		while (due_labels.size() != 0) @(posedge clk);
	endtask

	// Write one register; a write to either register clears the timer table
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_FILTER_MODE)
			mdl_mode = data[0];
		else if (idx == REG_TIMEOUT_TICKS)
			mdl_timeout = data;
		clear_timers();
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Let the block go idle, then set both registers in random order
	task automatic reconfigure(input logic [CFG_DATA_W-1:0] mode_word,
			input logic [TICK_W-1:0] ticks);
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if ($urandom_range(1)) begin
			write_reg(REG_FILTER_MODE, mode_word);
			write_reg(REG_TIMEOUT_TICKS, ticks);
		end else begin
			write_reg(REG_TIMEOUT_TICKS, ticks);
			write_reg(REG_FILTER_MODE, mode_word);
		end
	endtask

	// Random words: mostly labels from a small pool, plus ticks, nulls and noise
	task automatic random_words(input int count, input int pool_size, input int tick_pct);
		logic [LABEL_W-1:0] pool [24];
		int                 pick;

		for (int i = 0; i < 24; i++)
			pool[i] = LABEL_W'($urandom_range(1, 16'hFFFF));
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < tick_pct)
				send_tick();
			else if (pick < tick_pct + 8)
				send_label('0);
			else if (pick < tick_pct + 16)
				send_label(LABEL_W'($urandom));
			else
				send_label(pool[$urandom_range(pool_size - 1)]);
		end
	endtask

	// Reset values: shared mode with a zero timeout
	task automatic test_reset_state();
		send_label('0);
		send_label(16'hFFFF);
		send_label(16'hFFFF);
		send_tick();
	endtask

	// One shared timer: suppress while running, free on expiry
	task automatic test_shared_timeout();
		reconfigure({31'h7FFF_FFFF, MODE_SHARED}, 32'd2);
		send_label(16'd5);
		send_label(16'd7);
		send_label('0);
		send_tick();
		send_tick();
		send_tick();
		send_label('0);
		send_label(16'd3);
	endtask

	// Fill every entry with a never-ending timer, then overflow
	task automatic test_table_full();
		reconfigure({31'h0, MODE_INDEP}, 32'hFFFF_FFFF);
		for (int i = 0; i < MAX_TIMERS; i++)
			send_label(LABEL_W'(16'hFFFF - i * 16'h1111));
		send_label(16'h1234);
		send_label(16'hFFFF);
		send_tick();
	endtask

	// Hold results off long enough that the block backs up its input
	task automatic test_output_hold();
		reconfigure({31'h0, MODE_INDEP}, 32'd5);
		@(negedge clk);
		rx_hold = HOLD_CYCLES;
		random_words(40, 6, 20);
	endtask

	// Stop sending midway until all results are back
	task automatic test_sender_pause();
		reconfigure({31'h5555_5555, MODE_SHARED}, 32'd1);
		random_words(30, 4, 30);
		wait_drained();
		random_words(30, 4, 30);
	endtask

	// Sweep modes and timeouts in random phases
	task automatic test_random_mix();
		logic [TICK_W-1:0] ticks;
		logic              indep;

		for (int p = 0; p < 9; p++) begin
			case (p % 5)
				0: ticks = 32'd0;
				1: ticks = 32'd1;
				2: ticks = TICK_W'($urandom_range(2, 8));
				3: ticks = 32'hFFFF_FFFF;
				default: ticks = TICK_W'($urandom);
			endcase
			indep = (p % 2 == 1) ? MODE_INDEP : MODE_SHARED;
			reconfigure({31'($urandom), indep}, ticks);
			steady = (p == 4);
			random_words(200, $urandom_range(2, 24), $urandom_range(10, 40));
			steady = 1'b0;
		end
	endtask

	// Drive the output stall: long hold when asked, else random
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			result_stall <= 1'b1;
			rx_hold = rx_hold - 1;
		end else if (steady) begin
			result_stall <= 1'b0;
		end else begin
			result_stall <= ($urandom_range(99) < IDLE_PCT);
		end
	end

	// Compare each taken result with the oldest expected word
	always @(posedge clk) begin
		out_word_t want;

		if (arst_n && result_valid && !result_stall) begin
			if (due_labels.size() == 0) begin
				report_fault($sformatf("unexpected result label %h full %b",
					result.filtered_label, result.table_full));
			end else begin
				want = due_labels.pop_front();
				if (result.filtered_label !== want.filtered_label)
					report_fault($sformatf("filtered_label expected %h got %h",
						want.filtered_label, result.filtered_label));
				if (result.table_full !== want.table_full)
					report_fault($sformatf("table_full expected %b got %b",
						want.table_full, result.table_full));
			end
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		arst_n       = 1'b0;
		item_valid   = 1'b0;
		item         = '0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		result_stall = 1'b0;
		fault_count  = 0;
		quiet_cycles = 0;
		rx_hold      = 0;
		steady       = 1'b0;
		mdl_mode     = MODE_SHARED;
		mdl_timeout  = '0;
		clear_timers();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_shared_timeout();
		test_table_full();
		test_output_hold();
		test_sender_pause();
		test_random_mix();

		// Drain, then give stray results time to show up
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fault_count == 0 && due_labels.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
